@@ rtl/lzss_stream_decoder_macros.svh @@
// Assertion macros for the LZSS stream decoder RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef LZSS_STREAM_DECODER_MACROS_SVH
`define LZSS_STREAM_DECODER_MACROS_SVH
`ifndef SYNTH
`define LSD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LSD_ASSERT_RST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSD_ASSERT(label, clk, rst_n, prop, msg)
`define LSD_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

@@ rtl/lzss_pkg.sv @@
// Types and constants shared by the LZSS stream decoder modules.
// No dependencies.
`default_nettype none
package lzss_pkg;

	localparam int LEN_W = 9;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TRUNC   = 2'd1;
	localparam logic [1:0] ST_BADDIST = 2'd2;
	localparam logic [1:0] ST_OVERRUN = 2'd3;

	typedef enum logic [2:0] {
		PH_TAG,
		PH_LIT,
		PH_DLO,
		PH_DHI,
		PH_LEN
	} phase_t;

	typedef enum logic [1:0] {
		CMD_LIT,
		CMD_COPY,
		CMD_NOTE
	} cmd_kind_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_PUT,
		B_EMIT
	} back_state_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       first;
		logic       last;
	} in_t;

	typedef struct packed {
		logic [63:0] out_bytes;
		logic [3:0]  byte_count;
		logic        run_last;
		logic        stream_done;
		logic [1:0]  status;
	} out_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic             restart;
		logic [7:0]       data;
		logic [15:0]      distance;
		logic [LEN_W-1:0] len;
		logic             done;
		logic [1:0]       status;
	} cmd_t;

endpackage
`default_nettype wire

@@ rtl/lzss_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lzss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [WIDTH-1:0]           wdata,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/lzss_cmd_fifo.sv @@
// Short command queue between the token parser and the copy engine.
// Depends on lzss_pkg for the command type.
`default_nettype none
module lzss_cmd_fifo (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  lzss_pkg::cmd_t wdata,
	output logic           full,
	input  wire            pop,
	output lzss_pkg::cmd_t rdata,
	output logic           empty
);
	import lzss_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t            slot_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [PW:0]     cnt_q;

	assign full  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

@@ rtl/lzss_front.sv @@
// Token parser: takes compressed bytes, tracks tag bits and counts, decides
// end of stream and errors, and queues literal, copy and status commands.
// Depends on lzss_pkg.
`default_nettype none
module lzss_front #(
	parameter int WINDOW_BYTES = 4096,
	parameter int MATCH_BIAS   = 3
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire [31:0]     size_limit,
	input  wire            in_valid,
	output logic           in_stall,
	input  lzss_pkg::in_t  in_data,
	output logic           push,
	output lzss_pkg::cmd_t cmd,
	input  wire            full
);
	import lzss_pkg::*;

	phase_t       phase_q, ph, ph_n;
	logic [31:0]  bm_q, bm, bm_n;
	logic [7:0]   tag_q, tag, tag_n;
	logic [3:0]   idx_q, idx, idx_n;
	logic [15:0]  dist_q, distance, dist_n;
	logic         active_q, act_n;
	logic         pend_q, pend_n;
	logic         accept;
	logic         done;
	logic [1:0]   status;
	logic         has_bytes;
	logic [LEN_W-1:0] len;
	logic [32:0]  bm_end;

	assign accept   = in_valid && !full;
	assign in_stall = full;

	always_comb begin
		ph       = in_data.first ? PH_TAG : phase_q;
		bm       = in_data.first ? '0 : bm_q;
		tag      = in_data.first ? '0 : tag_q;
		idx      = in_data.first ? 4'd8 : idx_q;
		distance = in_data.first ? '0 : dist_q;
		ph_n   = ph;
		bm_n   = bm;
		tag_n  = tag;
		idx_n  = idx;
		dist_n = distance;
		act_n  = in_data.first || active_q;
		pend_n = in_data.first || pend_q;
		done   = 1'b0;
		status = ST_OK;
		has_bytes = 1'b0;
		push   = 1'b0;
		len    = LEN_W'(in_data.in_byte) + LEN_W'(MATCH_BIAS);
		bm_end = 33'(bm) + 33'(len);
		cmd    = '{kind: CMD_NOTE, restart: pend_n, data: in_data.in_byte,
			distance: distance, len: len, done: 1'b0, status: ST_OK};

		if (in_data.first && size_limit == '0) begin
			act_n    = 1'b0;
			push     = accept;
			cmd.done = 1'b1;
		end else if (act_n) begin
			unique case (ph)
				PH_TAG: begin
					tag_n = in_data.in_byte;
					idx_n = 4'd0;
					ph_n  = in_data.in_byte[0] ? PH_LIT : PH_DLO;
				end
				PH_LIT: begin
					cmd.kind  = CMD_LIT;
					has_bytes = 1'b1;
					bm_n      = bm + 32'd1;
				end
				PH_DLO: begin
					dist_n = {8'd0, in_data.in_byte};
					ph_n   = PH_DHI;
				end
				PH_DHI: begin
					dist_n = {in_data.in_byte, distance[7:0]};
					ph_n   = PH_LEN;
				end
				PH_LEN: begin
					if (distance == '0 || 32'(distance) > 32'(WINDOW_BYTES)
							|| 32'(distance) > bm) begin
						done   = 1'b1;
						status = ST_BADDIST;
					end else if (bm_end > 33'(size_limit)) begin
						done   = 1'b1;
						status = ST_OVERRUN;
					end else begin
						cmd.kind  = CMD_COPY;
						has_bytes = 1'b1;
						bm_n      = bm_end[31:0];
					end
				end
				default: ;
			endcase
			// advance to the next token after a literal or a finished copy
			if (has_bytes) begin
				idx_n = idx + 4'd1;
				if (idx_n >= 4'd8) begin
					idx_n = 4'd8;
					ph_n  = PH_TAG;
				end else begin
					ph_n = tag[idx_n[2:0]] ? PH_LIT : PH_DLO;
				end
			end
			if (!done && bm_n >= size_limit) begin
				done = 1'b1;
			end
			if (!done && in_data.last) begin
				done   = 1'b1;
				status = ST_TRUNC;
			end
			if (done) begin
				act_n = 1'b0;
			end
			cmd.done   = done;
			cmd.status = status;
			push       = accept && (has_bytes || done);
		end
		if (push) begin
			pend_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TAG;
			bm_q     <= '0;
			tag_q    <= '0;
			idx_q    <= 4'd8;
			dist_q   <= '0;
			active_q <= 1'b0;
			pend_q   <= 1'b0;
		end else if (accept) begin
			phase_q  <= ph_n;
			bm_q     <= bm_n;
			tag_q    <= tag_n;
			idx_q    <= idx_n;
			dist_q   <= dist_n;
			active_q <= act_n;
			pend_q   <= pend_n;
		end
	end
endmodule
`default_nettype wire

@@ rtl/lzss_back.sv @@
// Copy engine: executes queued commands, keeps the window RAM and write
// pointer, packs bytes into results and holds them in the output register.
// Depends on lzss_pkg, lzss_ram and the assertion macro header.
`default_nettype none
`include "lzss_stream_decoder_macros.svh"
module lzss_back #(
	parameter int WINDOW_BYTES = 4096,
	parameter int LANE_BYTES   = 8
) (
	input  wire            clk,
	input  wire            arst_n,
	input  lzss_pkg::cmd_t cmd,
	input  wire            empty,
	output logic           pop,
	output logic           out_valid,
	input  wire            out_stall,
	output lzss_pkg::out_t out_data
);
	import lzss_pkg::*;

	localparam int AW = $clog2(WINDOW_BYTES);

	back_state_t      st_q, st_n;
	logic [AW-1:0]    wp_q, wp_n, wp_base;
	logic [AW-1:0]    from_q, from_n;
	logic [LEN_W-1:0] rem_q, rem_n;
	logic [3:0]       cnt_q, cnt_n;
	logic [63:0]      lane_q, lane_n;
	logic             done_q, done_n;
	logic [1:0]       status_q, status_n;
	logic             out_valid_q;
	out_t             out_q;
	logic             load;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [7:0]       wdata;
	logic [7:0]       rdata;
	logic [16:0]      wpx;

	lzss_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_window (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (from_q),
		.rdata (rdata)
	);

	assign pop       = (st_q == B_IDLE) && !empty;
	assign load      = (st_q == B_EMIT) && (!out_valid_q || !out_stall);
	assign wp_base   = cmd.restart ? '0 : wp_q;
	assign wpx       = 17'(wp_base);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// next state
	always_comb begin
		st_n = st_q;
		unique case (st_q)
			B_IDLE: begin
				if (pop) begin
					st_n = (cmd.kind == CMD_COPY) ? B_READ : B_EMIT;
				end
			end
			B_READ: st_n = B_PUT;
			B_PUT: begin
				if (rem_q == LEN_W'(1) || cnt_q == 4'(LANE_BYTES - 1)) begin
					st_n = B_EMIT;
				end else begin
					st_n = B_READ;
				end
			end
			B_EMIT: begin
				if (load) begin
					st_n = (rem_q == '0) ? B_IDLE : B_READ;
				end
			end
			default: st_n = B_IDLE;
		endcase
	end

	// datapath
	always_comb begin
		wp_n     = wp_q;
		from_n   = from_q;
		rem_n    = rem_q;
		cnt_n    = cnt_q;
		lane_n   = lane_q;
		done_n   = done_q;
		status_n = status_q;
		we       = 1'b0;
		waddr    = wp_q;
		wdata    = rdata;
		unique case (st_q)
			B_IDLE: begin
				if (pop) begin
					done_n   = cmd.done;
					status_n = cmd.status;
					lane_n   = '0;
					cnt_n    = '0;
					rem_n    = '0;
					wp_n     = wp_base;
					if (cmd.kind == CMD_LIT) begin
						we     = 1'b1;
						waddr  = wp_base;
						wdata  = cmd.data;
						wp_n   = (wp_base == AW'(WINDOW_BYTES - 1)) ? '0 : wp_base + 1'b1;
						lane_n = {56'd0, cmd.data};
						cnt_n  = 4'd1;
					end else if (cmd.kind == CMD_COPY) begin
						rem_n = cmd.len;
						if (wpx >= 17'(cmd.distance)) begin
							from_n = AW'(wpx - 17'(cmd.distance));
						end else begin
							from_n = AW'(wpx + 17'(WINDOW_BYTES) - 17'(cmd.distance));
						end
					end
				end
			end
			B_READ: begin
				from_n = (from_q == AW'(WINDOW_BYTES - 1)) ? '0 : from_q + 1'b1;
			end
			B_PUT: begin
				we    = 1'b1;
				wp_n  = (wp_q == AW'(WINDOW_BYTES - 1)) ? '0 : wp_q + 1'b1;
				lane_n[{cnt_q[2:0], 3'b000} +: 8] = rdata;
				cnt_n = cnt_q + 4'd1;
				rem_n = rem_q - LEN_W'(1);
			end
			B_EMIT: begin
				if (load) begin
					lane_n = '0;
					cnt_n  = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_bytes   <= lane_q;
			out_q.byte_count  <= cnt_q;
			out_q.run_last    <= (rem_q == '0);
			out_q.stream_done <= (rem_q == '0) && done_q;
			out_q.status      <= ((rem_q == '0) && done_q) ? status_q : ST_OK;
		end
		from_q   <= from_n;
		rem_q    <= rem_n;
		cnt_q    <= cnt_n;
		lane_q   <= lane_n;
		done_q   <= done_n;
		status_q <= status_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			wp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q        <= st_n;
			wp_q        <= wp_n;
			out_valid_q <= load || (out_valid_q && out_stall);
		end
	end

	`LSD_ASSERT(a_count_fits, clk, arst_n, out_valid_q |-> out_q.byte_count <= 4'(LANE_BYTES), "result holds more bytes than a lane")
	`LSD_ASSERT(a_done_is_last, clk, arst_n, out_valid_q && out_q.stream_done |-> out_q.run_last, "stream end not on last result")
	`LSD_ASSERT(a_status_done, clk, arst_n, out_valid_q && out_q.status != ST_OK |-> out_q.stream_done, "error status without stream end")
	`LSD_ASSERT(a_put_has_work, clk, arst_n, st_q == B_PUT |-> rem_q != '0, "copy byte with nothing left to copy")
endmodule
`default_nettype wire

@@ rtl/lzss_stream_decoder.sv @@
// LZSS stream decoder, top level: parser, command queue and copy engine.
// Depends on lzss_pkg, lzss_front, lzss_cmd_fifo and lzss_back.
//
// Usage: write the output size limit through cfg_we/cfg_data while no stream
// is in flight. Compressed bytes arrive on in_valid/in_data and are taken when
// in_stall is low; the byte marked first starts a stream, bytes outside a
// stream are dropped. Results leave on out_valid/out_data, taken when
// out_stall is low; up to LANE_BYTES decoded bytes per result, run_last on
// the last result of an input byte, stream_done and status on the last of
// the stream.
// In the copy engine a literal is a command pop, then a result emit. A match
// pops the command, then reads and writes each copied byte (one read and one
// write of the single window RAM port pair) and emits each result; the
// two-entry command queue lets the parser run ahead meanwhile and in_stall
// rises when it fills. An accepted literal passes the command queue, the
// copy engine lane register and the output register before out_valid rises.
// Reset clears all control state and the pointers; window contents are
// undefined but unreachable. A stall on the output holds the result and
// backs up into the queue and then the input.
`default_nettype none
module lzss_stream_decoder #(
	parameter int WINDOW_BYTES = 4096,
	parameter int MATCH_BIAS   = 3,
	parameter int LANE_BYTES   = 8
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             cfg_we,
	input  wire [31:0]      cfg_data,
	input  wire             in_valid,
	output logic            in_stall,
	input  lzss_pkg::in_t   in_data,
	output logic            out_valid,
	input  wire             out_stall,
	output lzss_pkg::out_t  out_data
);
	import lzss_pkg::*;

	logic [31:0] size_limit_q;
	logic        push, full, pop, empty;
	cmd_t        cmd_in, cmd_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_limit_q <= '0;
		end else if (cfg_we) begin
			size_limit_q <= cfg_data;
		end
	end

	lzss_front #(.WINDOW_BYTES(WINDOW_BYTES), .MATCH_BIAS(MATCH_BIAS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.size_limit (size_limit_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.push       (push),
		.cmd        (cmd_in),
		.full       (full)
	);

	lzss_cmd_fifo u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (pop),
		.rdata  (cmd_out),
		.empty  (empty)
	);

	lzss_back #(.WINDOW_BYTES(WINDOW_BYTES), .LANE_BYTES(LANE_BYTES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);
endmodule
`default_nettype wire
